// File: rtl/dlcp_pkg.sv
`default_nettype none

package dlcp_pkg;

    // Link framing and payload markers
    localparam logic [7:0] HEADER_BYTE  = 8'hF0;
    localparam logic [7:0] ENABLE_BYTE  = 8'h0A;
    localparam logic [7:0] DISABLE_BYTE = 8'hB0;

    // Mode byte codes
    localparam logic [7:0] MODE_PARAM   = 8'd0;
    localparam logic [7:0] MODE_CHANNEL = 8'd1;
    localparam logic [7:0] MODE_ENABLE  = 8'd2;

    localparam int NUM_PARAMS   = 3;
    localparam int NUM_CHANNELS = 9;

    localparam int PAYLOAD_BYTES = 5;
    localparam int COUNT_W       = 3;
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(PAYLOAD_BYTES - 1);

    // Command queue between parser and executor
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PM_WAIT_HEADER,
        PM_WAIT_MODE,
        PM_PARAM,
        PM_CHANNEL,
        PM_ENABLE
    } parse_mode_t;

    typedef enum logic [1:0] {
        KIND_PARAM   = 2'd0,
        KIND_CHANNEL = 2'd1,
        KIND_ENABLE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  index;
        logic [31:0] word;
        logic        enable_set;
    } dlcp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/dlcp_front.sv
`default_nettype none

module dlcp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              queue_full,
    output logic                   push,
    output dlcp_pkg::dlcp_cmd_t    push_cmd
);
    import dlcp_pkg::*;

    parse_mode_t          state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [31:0]          buf_reg;
    logic                 accept;
    logic                 in_payload;
    logic                 last_byte;
    logic                 all_on;
    logic                 all_off;
    logic [31:0]          word;
    logic [7:0]           idx;

    assign in_stall   = queue_full;
    assign accept     = in_valid && !queue_full;
    assign in_payload = (state_reg == PM_PARAM) || (state_reg == PM_CHANNEL)
                        || (state_reg == PM_ENABLE);
    assign last_byte  = accept && in_payload && (count_reg == LAST_COUNT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            PM_WAIT_HEADER:
            begin
                if (accept && rx_byte == HEADER_BYTE)
                    state_next = PM_WAIT_MODE;
            end
            PM_WAIT_MODE:
            begin
                if (accept)
                begin
                    count_next = '0;
                    priority if (rx_byte == MODE_PARAM)
                        state_next = PM_PARAM;
                    else if (rx_byte == MODE_CHANNEL)
                        state_next = PM_CHANNEL;
                    else if (rx_byte == MODE_ENABLE)
                        state_next = PM_ENABLE;
                    else
                        state_next = PM_WAIT_MODE;
                end
            end
            PM_PARAM, PM_CHANNEL, PM_ENABLE:
            begin
                if (accept)
                begin
                    count_next = count_reg + 1'b1;
                    if (count_reg == LAST_COUNT)
                        state_next = PM_WAIT_HEADER;
                end
            end
            default:
            begin
                state_next = PM_WAIT_HEADER;
            end
        endcase
    end

    // Classify the finished payload
    assign idx     = buf_reg[31:24];
    assign word    = {buf_reg[23:0], rx_byte};
    assign all_on  = (buf_reg == {4{ENABLE_BYTE}})  && (rx_byte == ENABLE_BYTE);
    assign all_off = (buf_reg == {4{DISABLE_BYTE}}) && (rx_byte == DISABLE_BYTE);

    always_comb
    begin
        push                = 1'b0;
        push_cmd.kind       = KIND_PARAM;
        push_cmd.index      = idx[3:0];
        push_cmd.word       = word;
        push_cmd.enable_set = all_on;
        unique case (state_reg)
            PM_PARAM:
            begin
                push_cmd.kind = KIND_PARAM;
                push          = last_byte && (idx < 8'(NUM_PARAMS));
            end
            PM_CHANNEL:
            begin
                push_cmd.kind = KIND_CHANNEL;
                push          = last_byte && (idx < 8'(NUM_CHANNELS));
            end
            PM_ENABLE:
            begin
                push_cmd.kind  = KIND_ENABLE;
                push_cmd.index = '0;
                push_cmd.word  = '0;
                push           = last_byte && (all_on || all_off);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PM_WAIT_HEADER;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Shift in payload bytes, first byte ends up on top
    always_ff @(posedge clk)
    begin
        if (accept && in_payload)
            buf_reg <= {buf_reg[23:0], rx_byte};
    end

endmodule

`default_nettype wire

// File: rtl/dlcp_queue.sv
`default_nettype none

module dlcp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire dlcp_pkg::dlcp_cmd_t  push_cmd,
    output logic                      full,
    output logic                      head_valid,
    output dlcp_pkg::dlcp_cmd_t       head_cmd,
    input  wire logic                 pop
);
    import dlcp_pkg::*;

    dlcp_cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// File: rtl/dlcp_back.sv
`default_nettype none

module dlcp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire dlcp_pkg::dlcp_cmd_t  head_cmd,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                command_kind,
    output logic [3:0]                target_index,
    output logic [31:0]               value_bits,
    output logic [7:0]                channel_code,
    output logic                      stream_enable
);
    import dlcp_pkg::*;

    localparam logic [7:0] EXP_ONE    = 8'd127;
    localparam logic [7:0] EXP_SAT    = 8'd135;
    localparam logic [7:0] EXP_TOP    = 8'd134;
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;

    // Truncate toward zero, saturate to 0..255; sign set or NaN gives 0
    function automatic logic [7:0] word_to_code(input logic [31:0] w);
        logic [7:0] expo;
        logic [7:0] top;
        logic [2:0] sh;
        logic [7:0] code;
        expo = w[30:23];
        top  = {1'b1, w[22:16]};
        sh   = 3'(EXP_TOP - expo);
        priority if (w[31])
            code = 8'd0;
        else if (expo == EXP_SPECIAL)
            code = (|w[22:0]) ? 8'd0 : 8'hFF;
        else if (expo < EXP_ONE)
            code = 8'd0;
        else if (expo >= EXP_SAT)
            code = 8'hFF;
        else
            code = top >> sh;
        return code;
    endfunction

    logic         out_valid_reg, out_valid_next;
    logic         flag_reg, flag_next;
    cmd_kind_t    kind_reg;
    logic [3:0]   index_reg;
    logic [31:0]  word_reg;
    logic [7:0]   code_reg;
    logic [7:0]   code_next;

    // Load a new command when the output register is empty or being taken
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        code_next      = 8'd0;
        if (head_cmd.kind == KIND_CHANNEL)
            code_next = word_to_code(head_cmd.word);
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (head_cmd.kind == KIND_ENABLE)
                flag_next = head_cmd.enable_set;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= head_cmd.kind;
            index_reg <= head_cmd.index;
            word_reg  <= head_cmd.word;
            code_reg  <= code_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command_kind  = kind_reg;
    assign target_index  = index_reg;
    assign value_bits    = word_reg;
    assign channel_code  = code_reg;
    assign stream_enable = flag_reg;

endmodule

`default_nettype wire

// File: rtl/debug_link_command_parser.sv
// Channel | Signals                                   | Accepted when
// --------+-------------------------------------------+---------------------------
// input   | in_valid, in_stall, rx_byte               | in_valid && !in_stall
// output  | out_valid, out_stall, command_kind,       | out_valid && !out_stall
//         | target_index, value_bits, channel_code,   |
//         | stream_enable                             |
//
// One byte is taken every cycle unless in_stall is high; a command is queued, then loaded into the output register.
// The two-entry command queue and the output register absorb output stalls; in_stall
// rises only once the queue is full, i.e. three commands are pending.
// Reset (rst_n low, asynchronous) returns the parser to header search and clears the
// enable flag, the queue and the output valid.
`default_nettype none

module debug_link_command_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   rx_byte,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [1:0]        command_kind,
    output logic [3:0]        target_index,
    output logic [31:0]       value_bits,
    output logic [7:0]        channel_code,
    output logic              stream_enable
);
    import dlcp_pkg::*;

    logic       push;
    dlcp_cmd_t  push_cmd;
    logic       queue_full;
    logic       head_valid;
    dlcp_cmd_t  head_cmd;
    logic       pop;

    dlcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dlcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    dlcp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command_kind  (command_kind),
        .target_index  (target_index),
        .value_bits    (value_bits),
        .channel_code  (channel_code),
        .stream_enable (stream_enable)
    );

endmodule

`default_nettype wire

// File: rtl/dlcp_checker.sv
`default_nettype none

module dlcp_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_stall,
    input  wire logic         out_valid,
    input  wire logic         out_stall,
    input  wire logic [1:0]   command_kind,
    input  wire logic [3:0]   target_index,
    input  wire logic [31:0]  value_bits,
    input  wire logic [7:0]   channel_code,
    input  wire logic         stream_enable
);
    import dlcp_pkg::*;

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command_kind)
            && $stable(target_index) && $stable(value_bits)
            && $stable(channel_code) && $stable(stream_enable))
        else $error("output transaction changed while stalled");

    // The input stalls only behind a full queue, which sits behind a held output
    a_stall_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending output transaction");

    a_enable_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_kind == KIND_ENABLE |->
            target_index == 4'd0 && value_bits == 32'd0 && channel_code == 8'd0)
        else $error("enable command carries nonzero payload");

    a_param_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_kind == KIND_PARAM |->
            target_index < 4'(NUM_PARAMS) && channel_code == 8'd0)
        else $error("bad parameter command");

    a_channel_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_kind == KIND_CHANNEL |->
            target_index < 4'(NUM_CHANNELS)
            && (!value_bits[31] || channel_code == 8'd0))
        else $error("bad channel select command");

endmodule

bind debug_link_command_parser dlcp_checker u_dlcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command_kind  (command_kind),
    .target_index  (target_index),
    .value_bits    (value_bits),
    .channel_code  (channel_code),
    .stream_enable (stream_enable)
);

`default_nettype wire
